>>> hw/rtl/sdsd_pkg.sv
// Shared constants, codes and entry types of the sound data slot directory.
package sdsd_pkg;

    localparam int AUTO_SLOTS_DEF = 8;
    localparam int STAY_SLOTS_DEF = 16;

    localparam int SEQ_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int ORDER_W    = 32;
    localparam int SLOT_W     = 8;
    localparam int LOAD_W     = 8;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int LIMIT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ALIGN_W    = 5;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    // request codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLAIM      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_LOADED = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STAY_ALLOC = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_FAIL     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOADING  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_STAY_HIT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SLOT_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_BASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_BYTES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_LIMIT      = 3'd4;

    localparam logic [LIMIT_W-1:0] STAY_LIMIT_RST = 5'd16;
    localparam logic [SEQ_W-1:0]   SEQ_EMPTY      = '1;
    localparam logic [SLOT_W-1:0]  SLOT_NONE      = 8'hFF;
    localparam logic [LOAD_W-1:0]  LOADING_MARK   = 8'd1;
    localparam logic [ORDER_W-1:0] ORDER_MAX      = '1;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [LOAD_W-1:0]  loading;
        logic [ORDER_W-1:0] order;
        logic               in_use;
    } slot_entry_t;

    localparam slot_entry_t SLOT_ENTRY_RST = '{
        seq:     SEQ_EMPTY,
        loading: '0,
        order:   '0,
        in_use:  1'b0
    };

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
    } stay_entry_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } ram_ctl_t;

endpackage

>>> hw/rtl/sound_data_slot_directory.sv
// Sound data slot directory: replaceable slots plus a bump-allocated permanent area.
// Lookup walks the slot table, then the permanent entries, until a hit; find-slot walks
//   every slot; claim, release and set-loaded read the slot entry, then write it back.
// Throughput: one request at a time; the walk over the slot and permanent memories,
//   one entry read per cycle through a registered read port, sets the lookup time.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, async, active low) empties all slots at once through valid bits,
//   zeroes the load order counter and empties the permanent area; no clearing pass is needed.
module sound_data_slot_directory
    import sdsd_pkg::*;
#(
    parameter int AUTO_SLOTS = AUTO_SLOTS_DEF,
    parameter int STAY_SLOTS = STAY_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: seq_id[31:0], slot[39:32], size_bytes[71:40], loaded_value[79:72]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: slot_out[7:0], address[39:8]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int AIW  = (AUTO_SLOTS > 1) ? $clog2(AUTO_SLOTS) : 1;
    localparam int SIW  = (STAY_SLOTS > 1) ? $clog2(STAY_SLOTS) : 1;
    localparam int SCW  = $clog2(STAY_SLOTS + 1);
    localparam int MAXN = (AUTO_SLOTS > STAY_SLOTS) ? AUTO_SLOTS : STAY_SLOTS;
    localparam int NW   = $clog2(MAXN + 1);
    localparam int LCW  = (SCW > LIMIT_W) ? SCW : LIMIT_W;

    localparam logic [SLOT_W-1:0] SLOT_MISS = SLOT_W'(AUTO_SLOTS);

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LK_SLOT = 4'd1;
    localparam logic [3:0] ST_LK_STAY = 4'd2;
    localparam logic [3:0] ST_FIND    = 4'd3;
    localparam logic [3:0] ST_RMW_RD  = 4'd4;
    localparam logic [3:0] ST_RMW_WR  = 4'd5;
    localparam logic [3:0] ST_ALLOC   = 4'd6;
    localparam logic [3:0] ST_MUL     = 4'd7;
    localparam logic [3:0] ST_ADD     = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    // input fields
    logic [SEQ_W-1:0]  in_seq_id;
    logic [SLOT_W-1:0] in_slot;
    logic [ADDR_W-1:0] in_size;
    logic [LOAD_W-1:0] in_loaded;

    assign in_seq_id = s_axis_tdata[31:0];
    assign in_slot   = s_axis_tdata[39:32];
    assign in_size   = s_axis_tdata[71:40];
    assign in_loaded = s_axis_tdata[79:72];

    // configuration registers
    logic [ADDR_W-1:0]  auto_base_reg;
    logic [ADDR_W-1:0]  auto_slot_bytes_reg;
    logic [ADDR_W-1:0]  stay_base_reg;
    logic [ADDR_W-1:0]  stay_bytes_reg;
    logic [LIMIT_W-1:0] stay_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_base_reg       <= '0;
            auto_slot_bytes_reg <= '0;
            stay_base_reg       <= '0;
            stay_bytes_reg      <= '0;
            stay_limit_reg      <= STAY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AUTO_BASE:       auto_base_reg       <= cfg_data;
                REG_AUTO_SLOT_BYTES: auto_slot_bytes_reg <= cfg_data;
                REG_STAY_BASE:       stay_base_reg       <= cfg_data;
                REG_STAY_BYTES:      stay_bytes_reg      <= cfg_data;
                REG_STAY_LIMIT:      stay_limit_reg      <= cfg_data[LIMIT_W-1:0];
                default: ; // indexes past the register list are dropped
            endcase
        end
    end

    // sequencer and datapath registers
    logic [3:0]          state_reg,      state_next;
    logic [MODE_W-1:0]   mode_reg,       mode_next;
    logic [SEQ_W-1:0]    seq_id_reg,     seq_id_next;
    logic [SLOT_W-1:0]   slot_reg,       slot_next;
    logic [ADDR_W-1:0]   size_reg,       size_next;
    logic [LOAD_W-1:0]   loaded_reg,     loaded_next;
    logic [NW-1:0]       scan_idx_reg,   scan_idx_next;
    logic                chk_vld_reg,    chk_vld_next;
    logic [NW-1:0]       chk_idx_reg,    chk_idx_next;
    logic                have_empty_reg, have_empty_next;
    logic [AIW-1:0]      empty_idx_reg,  empty_idx_next;
    logic                have_best_reg,  have_best_next;
    logic [AIW-1:0]      best_idx_reg,   best_idx_next;
    logic [ORDER_W-1:0]  best_order_reg, best_order_next;
    logic [AIW-1:0]      mul_idx_reg,    mul_idx_next;
    logic [ADDR_W-1:0]   prod_reg,       prod_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg,   res_slot_next;
    logic [ADDR_W-1:0]   res_addr_reg,   res_addr_next;
    logic                out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg,   out_slot_next;
    logic [ADDR_W-1:0]   out_addr_reg,   out_addr_next;
    logic [ORDER_W-1:0]  next_order_reg, next_order_next;
    logic [SCW-1:0]      stay_count_reg, stay_count_next;
    logic [ADDR_W-1:0]   stay_off_reg,   stay_off_next;

    // slot table port
    ram_ctl_t       slot_ctl;
    logic [AIW-1:0] slot_addr;
    slot_entry_t    slot_wdata;
    slot_entry_t    slot_rdata;

    sdsd_slot_store #(
        .AUTO_SLOTS (AUTO_SLOTS)
    ) u_slot_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (slot_ctl),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    // permanent entry memory; entries at or above stay_count are never read
    stay_entry_t    stay_mem [STAY_SLOTS];
    stay_entry_t    stay_rd_reg;
    logic           stay_rd;
    logic           stay_wr;
    logic [SIW-1:0] stay_addr;
    stay_entry_t    stay_wdata;

    always_ff @(posedge clk)
    begin
        if (stay_wr)
        begin
            stay_mem[stay_addr] <= stay_wdata;
        end
        if (stay_rd)
        begin
            stay_rd_reg <= stay_mem[stay_addr];
        end
    end

    // permanent allocate checks
    logic [LCW-1:0]    lim_w;
    logic              stay_full;
    logic [ADDR_W:0]   alloc_end;
    logic              no_room;
    logic [ADDR_W:0]   rounded;
    logic [ADDR_W+1:0] new_off;

    always_comb
    begin
        lim_w = (LCW'(stay_limit_reg) < LCW'(STAY_SLOTS)) ? LCW'(stay_limit_reg)
                                                           : LCW'(STAY_SLOTS);
        stay_full = LCW'(stay_count_reg) >= lim_w;
        alloc_end = {1'b0, size_reg} + {1'b0, stay_off_reg};
        no_room   = alloc_end >= {1'b0, stay_bytes_reg};
        // round the size up to the next 32-byte boundary
        rounded   = {1'b0, size_reg[ADDR_W-1:ALIGN_W], {ALIGN_W{1'b0}}}
                  + ((|size_reg[ALIGN_W-1:0]) ? (ADDR_W+1)'(1 << ALIGN_W) : '0);
        new_off   = {2'b00, stay_off_reg} + {1'b0, rounded};
    end

    // scan control shared by the lookup and find walks
    logic issue_slot;
    logic issue_stay;

    assign issue_slot = scan_idx_reg < NW'(AUTO_SLOTS);
    assign issue_stay = scan_idx_reg < NW'(stay_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        seq_id_next     = seq_id_reg;
        slot_next       = slot_reg;
        size_next       = size_reg;
        loaded_next     = loaded_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        have_empty_next = have_empty_reg;
        empty_idx_next  = empty_idx_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_order_next = best_order_reg;
        mul_idx_next    = mul_idx_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_addr_next   = out_addr_reg;
        next_order_next = next_order_reg;
        stay_count_next = stay_count_reg;
        stay_off_next   = stay_off_reg;

        slot_ctl        = '{rd: 1'b0, wr: 1'b0};
        slot_addr       = scan_idx_reg[AIW-1:0];
        slot_wdata      = slot_rdata;
        stay_rd         = 1'b0;
        stay_wr         = 1'b0;
        stay_addr       = scan_idx_reg[SIW-1:0];
        stay_wdata      = '{seq: seq_id_reg, addr: stay_base_reg + stay_off_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next       = s_axis_tuser;
                    seq_id_next     = in_seq_id;
                    slot_next       = in_slot;
                    size_next       = in_size;
                    loaded_next     = in_loaded;
                    scan_idx_next   = '0;
                    have_empty_next = 1'b0;
                    have_best_next  = 1'b0;
                    best_order_next = ORDER_MAX;
                    case (s_axis_tuser) inside
                        MODE_LOOKUP:
                        begin
                            state_next = ST_LK_SLOT;
                        end
                        MODE_FIND:
                        begin
                            state_next = ST_FIND;
                        end
                        MODE_CLAIM, MODE_RELEASE, MODE_SET_LOADED:
                        begin
                            if (in_slot >= SLOT_MISS)
                            begin
                                // slot out of range: answer and change nothing
                                res_status_next = STATUS_FAIL;
                                res_slot_next   = in_slot;
                                res_addr_next   = '0;
                                state_next      = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_RMW_RD;
                            end
                        end
                        MODE_STAY_ALLOC:
                        begin
                            state_next = ST_ALLOC;
                        end
                        default:
                        begin
                            res_status_next = STATUS_FAIL;
                            res_slot_next   = '0;
                            res_addr_next   = '0;
                            state_next      = ST_OUT;
                        end
                    endcase
                end
            end

            ST_LK_SLOT:
            begin
                slot_ctl.rd   = issue_slot;
                chk_vld_next  = issue_slot;
                chk_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + NW'(issue_slot);
                if (chk_vld_reg && slot_rdata.seq == seq_id_reg)
                begin
                    res_slot_next = SLOT_W'(chk_idx_reg);
                    chk_vld_next  = 1'b0;
                    if (slot_rdata.loading == LOADING_MARK)
                    begin
                        res_status_next = STATUS_LOADING;
                        res_addr_next   = '0;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        res_status_next = STATUS_OK;
                        mul_idx_next    = chk_idx_reg[AIW-1:0];
                        state_next      = ST_MUL;
                    end
                end
                else if (!chk_vld_reg && !issue_slot)
                begin
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    state_next    = ST_LK_STAY;
                end
            end

            ST_LK_STAY:
            begin
                stay_rd       = issue_stay;
                chk_vld_next  = issue_stay;
                scan_idx_next = scan_idx_reg + NW'(issue_stay);
                if (chk_vld_reg && stay_rd_reg.seq == seq_id_reg)
                begin
                    res_status_next = STATUS_STAY_HIT;
                    res_slot_next   = SLOT_NONE;
                    res_addr_next   = stay_rd_reg.addr;
                    chk_vld_next    = 1'b0;
                    state_next      = ST_OUT;
                end
                else if (!chk_vld_reg && !issue_stay)
                begin
                    res_status_next = STATUS_FAIL;
                    res_slot_next   = SLOT_MISS;
                    res_addr_next   = '0;
                    state_next      = ST_OUT;
                end
            end

            ST_FIND:
            begin
                slot_ctl.rd   = issue_slot;
                chk_vld_next  = issue_slot;
                chk_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + NW'(issue_slot);
                if (chk_vld_reg)
                begin
                    if (slot_rdata.seq == SEQ_EMPTY && !have_empty_reg)
                    begin
                        have_empty_next = 1'b1;
                        empty_idx_next  = chk_idx_reg[AIW-1:0];
                    end
                    // oldest released slot; the first one wins a tie
                    if (!slot_rdata.in_use && slot_rdata.order < best_order_reg)
                    begin
                        have_best_next  = 1'b1;
                        best_idx_next   = chk_idx_reg[AIW-1:0];
                        best_order_next = slot_rdata.order;
                    end
                end
                else if (!issue_slot)
                begin
                    if (have_empty_reg || have_best_reg)
                    begin
                        mul_idx_next    = have_empty_reg ? empty_idx_reg : best_idx_reg;
                        res_status_next = STATUS_OK;
                        res_slot_next   = SLOT_W'(have_empty_reg ? empty_idx_reg
                                                                 : best_idx_reg);
                        state_next      = ST_MUL;
                    end
                    else
                    begin
                        res_status_next = STATUS_FAIL;
                        res_slot_next   = SLOT_MISS;
                        res_addr_next   = '0;
                        state_next      = ST_OUT;
                    end
                end
            end

            ST_RMW_RD:
            begin
                slot_ctl.rd = 1'b1;
                slot_addr   = slot_reg[AIW-1:0];
                state_next  = ST_RMW_WR;
            end

            ST_RMW_WR:
            begin
                slot_ctl.wr     = 1'b1;
                slot_addr       = slot_reg[AIW-1:0];
                res_status_next = STATUS_OK;
                res_slot_next   = slot_reg;
                res_addr_next   = '0;
                state_next      = ST_OUT;
                case (mode_reg)
                    MODE_CLAIM:
                    begin
                        slot_wdata.seq    = seq_id_reg;
                        slot_wdata.in_use = 1'b1;
                        slot_wdata.order  = next_order_reg;
                        next_order_next   = next_order_reg + ORDER_W'(1);
                        mul_idx_next      = slot_reg[AIW-1:0];
                        state_next        = ST_MUL;
                    end
                    MODE_RELEASE:
                    begin
                        slot_wdata.in_use = 1'b0;
                    end
                    default:
                    begin
                        slot_wdata.loading = loaded_reg;
                    end
                endcase
            end

            ST_ALLOC:
            begin
                res_slot_next = SLOT_NONE;
                state_next    = ST_OUT;
                if (stay_full || no_room)
                begin
                    res_status_next = STATUS_FAIL;
                    res_addr_next   = '0;
                end
                else
                begin
                    stay_wr         = 1'b1;
                    stay_addr       = stay_count_reg[SIW-1:0];
                    stay_count_next = stay_count_reg + SCW'(1);
                    // saturate the bump pointer at the top of the address space
                    stay_off_next   = new_off[ADDR_W+1:ADDR_W] != 2'b00 ? '1
                                                                        : new_off[ADDR_W-1:0];
                    res_status_next = STATUS_OK;
                    res_addr_next   = stay_base_reg + stay_off_reg;
                end
            end

            ST_MUL:
            begin
                prod_next  = auto_slot_bytes_reg * {{(ADDR_W-AIW){1'b0}}, mul_idx_reg};
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                res_addr_next = auto_base_reg + prod_reg;
                state_next    = ST_OUT;
            end

            ST_OUT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chk_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            next_order_reg <= '0;
            stay_count_reg <= '0;
            stay_off_reg   <= '0;
            scan_idx_reg   <= '0;
            have_empty_reg <= 1'b0;
            have_best_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            out_valid_reg  <= out_valid_next;
            next_order_reg <= next_order_next;
            stay_count_reg <= stay_count_next;
            stay_off_reg   <= stay_off_next;
            scan_idx_reg   <= scan_idx_next;
            have_empty_reg <= have_empty_next;
            have_best_reg  <= have_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        seq_id_reg     <= seq_id_next;
        slot_reg       <= slot_next;
        size_reg       <= size_next;
        loaded_reg     <= loaded_next;
        chk_idx_reg    <= chk_idx_next;
        empty_idx_reg  <= empty_idx_next;
        best_idx_reg   <= best_idx_next;
        best_order_reg <= best_order_next;
        mul_idx_reg    <= mul_idx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_addr_reg   <= out_addr_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_addr_reg, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

>>> hw/rtl/sdsd_slot_store.sv
// Replaceable slot table: synchronous memory with per-entry valid bits.
module sdsd_slot_store
    import sdsd_pkg::*;
#(
    parameter int AUTO_SLOTS = AUTO_SLOTS_DEF,
    localparam int AIW = (AUTO_SLOTS > 1) ? $clog2(AUTO_SLOTS) : 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ram_ctl_t       ctl,
    input  logic [AIW-1:0] addr,
    input  slot_entry_t    wdata,
    output slot_entry_t    rdata
);

    slot_entry_t           mem [AUTO_SLOTS];
    slot_entry_t           rd_reg;
    logic [AUTO_SLOTS-1:0] vld_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    // an entry never written reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_vld_reg <= vld_reg[addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : SLOT_ENTRY_RST;

endmodule

>>> hw/rtl/sdsd_checker.sv
// Port-level checks of the sound data slot directory, bound to the top level.
module sdsd_checker
    import sdsd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser
);

    // the output register is cleared by reset, so check at the following clock edge
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while one is in work");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_stay_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_STAY_HIT |->
            m_axis_tdata[SLOT_W-1:0] == SLOT_NONE)
        else $error("permanent hit without the no-slot index");

    a_loading_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_LOADING |->
            m_axis_tdata[OUT_DATA_W-1:SLOT_W] == '0)
        else $error("loading slot reported with an address");

endmodule

bind sound_data_slot_directory sdsd_checker u_sdsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/sound_data_slot_directory_test.sv
`timescale 1ns / 1ps
// Self-checking test of the sound data slot directory: directed cases and random traffic.
module sound_data_slot_directory_test;
    import sdsd_pkg::*;

    localparam int AUTO = AUTO_SLOTS_DEF;
    localparam int STAY = STAY_SLOTS_DEF;

    // request codes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // id pools: replaceable sounds and permanent sounds never collide
    localparam logic [SEQ_W-1:0] SOUND_ID_BASE = 32'h0100_0000;
    localparam logic [SEQ_W-1:0] STAY_ID_BASE  = 32'h0200_0000;

    // longest lookup walk plus margin
    localparam int SETTLE_CYCLES = AUTO + STAY + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [ADDR_W-1:0]   address;
    } answer_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // expected answers, oldest first
    answer_t     pending_answers[$];
    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned items_sent     = 0;
    // when set, neither side idles
    bit          quiet_stretch  = 1'b0;

    // mirror of the directory state
    logic [SEQ_W-1:0]   slot_ids    [AUTO];
    logic [LOAD_W-1:0]  slot_flags  [AUTO];
    logic [ORDER_W-1:0] slot_orders [AUTO];
    logic               slot_held   [AUTO];
    logic [ORDER_W-1:0] order_counter;
    logic [SEQ_W-1:0]   stay_ids    [STAY];
    logic [ADDR_W-1:0]  stay_addrs  [STAY];
    int unsigned        stay_used;
    logic [ADDR_W-1:0]  stay_fill;

    // mirror of the configuration registers
    logic [31:0]        auto_base_cfg;
    logic [31:0]        auto_spacing_cfg;
    logic [31:0]        stay_base_cfg;
    logic [31:0]        stay_bytes_cfg;
    logic [LIMIT_W-1:0] stay_limit_cfg;

    sound_data_slot_directory #(
        .AUTO_SLOTS (AUTO),
        .STAY_SLOTS (STAY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_directory();
        for (int i = 0; i < AUTO; i++)
        begin
            slot_ids[i]    = SEQ_EMPTY;
            slot_flags[i]  = '0;
            slot_orders[i] = '0;
            slot_held[i]   = 1'b0;
        end
        for (int i = 0; i < STAY; i++)
        begin
            stay_ids[i]   = '0;
            stay_addrs[i] = '0;
        end
        order_counter    = '0;
        stay_used        = 0;
        stay_fill        = '0;
        auto_base_cfg    = '0;
        auto_spacing_cfg = '0;
        stay_base_cfg    = '0;
        stay_bytes_cfg   = '0;
        stay_limit_cfg   = STAY_LIMIT_RST;
    endfunction

    function automatic answer_t make_answer(input logic [STATUS_W-1:0] status,
                                            input logic [SLOT_W-1:0] slot_out,
                                            input logic [ADDR_W-1:0] address);
        answer_t ans;
        ans.status   = status;
        ans.slot_out = slot_out;
        ans.address  = address;
        return ans;
    endfunction

    // Slot addresses wrap modulo 2^32.
    function automatic logic [ADDR_W-1:0] slot_address(input int unsigned slot);
        logic [31:0] slot32;
        logic [31:0] offset;
        slot32 = slot;
        offset = slot32 * auto_spacing_cfg;
        return auto_base_cfg + offset;
    endfunction

    // First empty slot wins; otherwise the released slot claimed longest ago.
    // Returns AUTO when nothing can be replaced.
    function automatic int unsigned free_slot_choice();
        logic [ORDER_W-1:0] oldest;
        int unsigned        pick;
        oldest = ORDER_MAX;
        pick   = AUTO;
        for (int i = 0; i < AUTO; i++)
            if (slot_ids[i] == SEQ_EMPTY)
                return i;
        for (int i = 0; i < AUTO; i++)
        begin
            if (!slot_held[i] && slot_orders[i] < oldest)
            begin
                oldest = slot_orders[i];
                pick   = i;
            end
        end
        return pick;
    endfunction

    // Apply one request to the mirrored directory and return the answer it must give.
    function automatic answer_t serve_request(input logic [MODE_W-1:0] mode,
                                              input logic [SEQ_W-1:0] id,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [31:0] size,
                                              input logic [LOAD_W-1:0] flag);
        answer_t     ans;
        bit          found;
        int unsigned pick;
        int unsigned cap;
        logic [33:0] span;
        logic [33:0] total;
        ans   = make_answer(STATUS_FAIL, '0, '0);
        found = 1'b0;
        case (mode)
            MODE_LOOKUP:
            begin
                ans = make_answer(STATUS_FAIL, SLOT_W'(AUTO), '0);
                for (int i = 0; i < AUTO && !found; i++)
                begin
                    if (slot_ids[i] == id)
                    begin
                        found = 1'b1;
                        if (slot_flags[i] == LOADING_MARK)
                            ans = make_answer(STATUS_LOADING, SLOT_W'(i), '0);
                        else
                            ans = make_answer(STATUS_OK, SLOT_W'(i), slot_address(i));
                    end
                end
                for (int i = 0; i < stay_used && !found; i++)
                begin
                    if (stay_ids[i] == id)
                    begin
                        found = 1'b1;
                        ans = make_answer(STATUS_STAY_HIT, SLOT_NONE, stay_addrs[i]);
                    end
                end
            end
            MODE_FIND:
            begin
                pick = free_slot_choice();
                if (pick < AUTO)
                    ans = make_answer(STATUS_OK, SLOT_W'(pick), slot_address(pick));
                else
                    ans = make_answer(STATUS_FAIL, SLOT_W'(AUTO), '0);
            end
            MODE_CLAIM, MODE_RELEASE, MODE_SET_LOADED:
            begin
                if (slot >= AUTO)
                    ans = make_answer(STATUS_FAIL, slot, '0);
                else if (mode == MODE_CLAIM)
                begin
                    slot_ids[slot]    = id;
                    slot_held[slot]   = 1'b1;
                    slot_orders[slot] = order_counter;
                    order_counter     = order_counter + 1'b1;
                    ans = make_answer(STATUS_OK, slot, slot_address(32'(slot)));
                end
                else if (mode == MODE_RELEASE)
                begin
                    slot_held[slot] = 1'b0;
                    ans = make_answer(STATUS_OK, slot, '0);
                end
                else
                begin
                    slot_flags[slot] = flag;
                    ans = make_answer(STATUS_OK, slot, '0);
                end
            end
            MODE_STAY_ALLOC:
            begin
                cap = (stay_limit_cfg < STAY) ? stay_limit_cfg : STAY;
                // the end of the request must stay strictly below the area size, no wrap
                if (stay_used >= cap ||
                    ({1'b0, size} + {1'b0, stay_fill}) >= {1'b0, stay_bytes_cfg})
                    ans = make_answer(STATUS_FAIL, SLOT_NONE, '0);
                else
                begin
                    ans = make_answer(STATUS_OK, SLOT_NONE, stay_base_cfg + stay_fill);
                    stay_ids[stay_used]   = id;
                    stay_addrs[stay_used] = ans.address;
                    stay_used++;
                    // round up to 32 bytes, saturate the bump pointer at all ones
                    span  = {2'b00, size & ~32'h1F} + ((size[4:0] != 5'd0) ? 34'd32 : 34'd0);
                    total = {2'b00, stay_fill} + span;
                    stay_fill = (total > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                end
            end
            default:
                ans = make_answer(STATUS_FAIL, '0, '0);
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Receiver: drop ready at random, with a chance of 19 in 100, unless in a quiet stretch.
    always @(posedge clk)
        m_axis_tready <= quiet_stretch || ($urandom_range(99) >= 19);

    // Compare each result transfer with the oldest expected answer.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (pending_answers.size() == 0)
                report_mismatch($sformatf("result %0d unexpected: status %0d slot %0d addr %h",
                    result_count, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8]));
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                        result_count, m_axis_tuser, want.status));
                if (m_axis_tdata[7:0] !== want.slot_out)
                    report_mismatch($sformatf("result %0d slot %0d, expected %0d",
                        result_count, m_axis_tdata[7:0], want.slot_out));
                if (m_axis_tdata[39:8] !== want.address)
                    report_mismatch($sformatf("result %0d address %h, expected %h",
                        result_count, m_axis_tdata[39:8], want.address));
            end
        end
    end

    // Send one request. Valid stays high on return so back-to-back transfers need
    // no lower/raise in one step; an idle cycle or a drain lowers it.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [SEQ_W-1:0] id,
                                input logic [SLOT_W-1:0] slot,
                                input logic [31:0] size,
                                input logic [LOAD_W-1:0] flag);
        while (!quiet_stretch && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {flag, size, slot, id};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // transfer taken at this edge: advance the mirror in request order
        pending_answers.push_back(serve_request(mode, id, slot, size, flag));
        items_sent++;
    endtask

    // Hold off the sender until every expected result has been seen.
    task automatic wait_for_answers();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_AUTO_BASE:       auto_base_cfg    = value;
            REG_AUTO_SLOT_BYTES: auto_spacing_cfg = value;
            REG_STAY_BASE:       stay_base_cfg    = value;
            REG_STAY_BYTES:      stay_bytes_cfg   = value;
            REG_STAY_LIMIT:      stay_limit_cfg   = value[LIMIT_W-1:0];
            default:             ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the block idle.
    task automatic apply_settings(input logic [31:0] auto_base, input logic [31:0] spacing,
                                  input logic [31:0] stay_base, input logic [31:0] stay_bytes,
                                  input logic [31:0] stay_limit);
        wait_for_answers();
        write_reg(REG_AUTO_BASE, auto_base);
        write_reg(REG_AUTO_SLOT_BYTES, spacing);
        write_reg(REG_STAY_BASE, stay_base);
        write_reg(REG_STAY_BYTES, stay_bytes);
        write_reg(REG_STAY_LIMIT, stay_limit);
    endtask

    function automatic logic [SEQ_W-1:0] pick_sound_id();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return SEQ_EMPTY;
        else if (roll < 20)
            return STAY_ID_BASE + $urandom_range(0, 7);
        else
            return SOUND_ID_BASE + $urandom_range(0, 11);
    endfunction

    // The usual load flow: find a slot, claim it, mark it loading, look it up,
    // finish loading, look it up again.
    task automatic load_sound(input logic [SEQ_W-1:0] id);
        int unsigned target;
        send_request(MODE_FIND, $urandom(), 8'($urandom()), $urandom(), 8'($urandom()));
        target = free_slot_choice();
        if (target < AUTO)
        begin
            send_request(MODE_CLAIM, id, SLOT_W'(target), $urandom(), 8'($urandom()));
            send_request(MODE_SET_LOADED, $urandom(), SLOT_W'(target), $urandom(),
                LOADING_MARK);
            send_request(MODE_LOOKUP, id, 8'($urandom()), $urandom(), 8'($urandom()));
            send_request(MODE_SET_LOADED, $urandom(), SLOT_W'(target), $urandom(),
                $urandom_range(0, 1) ? 8'd0 : 8'($urandom()));
            send_request(MODE_LOOKUP, id, 8'($urandom()), $urandom(), 8'($urandom()));
        end
    endtask

    // Any mode, any slot, any size: out-of-range and unused codes included.
    task automatic noise_request();
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  id;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       size;
        mode = MODE_W'($urandom_range(0, 7));
        id   = $urandom_range(0, 1) ? $urandom() : pick_sound_id();
        case ($urandom_range(0, 3))
            0:       slot = SLOT_W'($urandom());
            1:       slot = SLOT_W'($urandom_range(AUTO, 254));
            default: slot = SLOT_W'($urandom_range(0, AUTO - 1));
        endcase
        size = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
        send_request(mode, id, slot, size, 8'($urandom()));
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned first;
        int unsigned roll;
        bit          paused;
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < count)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                load_sound(pick_sound_id());
            else if (roll < 55)
                send_request(MODE_LOOKUP, pick_sound_id(), 8'($urandom()), $urandom(),
                    8'($urandom()));
            else if (roll < 65)
                send_request(MODE_RELEASE, $urandom(), SLOT_W'($urandom_range(0, AUTO - 1)),
                    $urandom(), 8'($urandom()));
            else if (roll < 70)
                send_request(MODE_STAY_ALLOC, STAY_ID_BASE + $urandom_range(0, 7),
                    8'($urandom()), $urandom_range(0, 300), 8'($urandom()));
            else
                noise_request();
            // once per phase, let the block run dry before going on
            if (!paused && items_sent - first >= count / 2)
            begin
                wait_for_answers();
                paused = 1'b1;
            end
        end
    endtask

    // Reset values: every slot empty, permanent area zero-sized.
    task automatic test_empty_directory();
        // all-ones id matches the first empty slot
        send_request(MODE_LOOKUP, SEQ_EMPTY, 8'h00, 32'h0, 8'h00);
        send_request(MODE_LOOKUP, 32'h0, SLOT_NONE, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_FIND, 32'h0, 8'h00, 32'h0, 8'h00);
        // zero-sized area: any allocation fails
        send_request(MODE_STAY_ALLOC, 32'h1, 8'h00, 32'h0, 8'h00);
        send_request(MODE_SPARE_LO, SEQ_EMPTY, SLOT_NONE, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_SPARE_HI, 32'h0, 8'h00, 32'h0, 8'h00);
        // slots past the end are left alone
        send_request(MODE_CLAIM, SOUND_ID_BASE, SLOT_W'(AUTO), 32'h0, 8'h00);
        send_request(MODE_SET_LOADED, 32'h0, SLOT_NONE, 32'h0, LOADING_MARK);
    endtask

    // Fill every slot, then exercise loading, release and oldest-first replacement.
    task automatic test_slot_replacement();
        apply_settings(32'h8000_0000, 32'h0001_0000, 32'h0040_0000, 32'h0000_0200, 32'd2);
        for (int i = 0; i < AUTO - 1; i++)
            send_request(MODE_CLAIM, SOUND_ID_BASE + i, SLOT_W'(i), $urandom(), 8'($urandom()));
        // a slot claimed with the all-ones id still reads as empty
        send_request(MODE_CLAIM, SEQ_EMPTY, SLOT_W'(AUTO - 1), $urandom(), 8'($urandom()));
        send_request(MODE_FIND, $urandom(), 8'($urandom()), $urandom(), 8'($urandom()));
        send_request(MODE_LOOKUP, SEQ_EMPTY, 8'($urandom()), $urandom(), 8'($urandom()));
        send_request(MODE_CLAIM, SOUND_ID_BASE + AUTO - 1, SLOT_W'(AUTO - 1), $urandom(),
            8'($urandom()));
        // every slot held and none empty: nothing to hand out
        send_request(MODE_FIND, $urandom(), 8'($urandom()), $urandom(), 8'($urandom()));
        send_request(MODE_SET_LOADED, $urandom(), 8'd2, $urandom(), LOADING_MARK);
        send_request(MODE_LOOKUP, SOUND_ID_BASE + 2, 8'($urandom()), $urandom(), 8'($urandom()));
        send_request(MODE_SET_LOADED, $urandom(), 8'd2, $urandom(), 8'hFF);
        send_request(MODE_LOOKUP, SOUND_ID_BASE + 2, 8'($urandom()), $urandom(), 8'($urandom()));
        // two released: the one claimed first goes
        send_request(MODE_RELEASE, $urandom(), 8'd5, $urandom(), 8'($urandom()));
        send_request(MODE_RELEASE, $urandom(), 8'd3, $urandom(), 8'($urandom()));
        send_request(MODE_FIND, $urandom(), 8'($urandom()), $urandom(), 8'($urandom()));
    endtask

    // Bump allocation: zero limit, size limit, rounding, address wrap, count limit.
    task automatic test_permanent_area();
        apply_settings(32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFF0, 32'h0000_0200, 32'd0);
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE, 8'h00, 32'd1, 8'h00);
        apply_settings(32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFF0, 32'h0000_0200, 32'd2);
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE, 8'h00, 32'd1, 8'h00);
        // end would land exactly on the area size
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE + 1, 8'h00, 32'h0000_01E0, 8'h00);
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE + 1, 8'h00, 32'd33, 8'h00);
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE + 2, 8'h00, 32'd0, 8'h00);
        send_request(MODE_LOOKUP, STAY_ID_BASE + 1, 8'($urandom()), $urandom(), 8'($urandom()));
    endtask

    task automatic test_random_traffic();
        apply_settings($urandom(), $urandom_range(1, 4096), $urandom(), 32'h0000_4000, 32'd8);
        random_traffic(300);
        // extremes of the slot address registers, with no idling on either side
        quiet_stretch = 1'b1;
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(), $urandom(),
            $urandom_range(9, 12));
        random_traffic(300);
        quiet_stretch = 1'b0;
        apply_settings(32'h0, 32'h0, 32'hFFFF_FFE0, 32'hFFFF_FFFF, 32'd12);
        random_traffic(300);
    endtask

    // Push the bump pointer past 2^32 - 1 so it pins at all ones.
    task automatic test_offset_saturation();
        logic [31:0] size;
        apply_settings($urandom(), $urandom(), $urandom(), 32'hFFFF_FFFF, 32'd16);
        size = (stay_fill < 32'hFFFF_FFFE) ? 32'hFFFF_FFFE - stay_fill : 32'd0;
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE + 32'h100, 8'h00, size, 8'h00);
        send_request(MODE_STAY_ALLOC, STAY_ID_BASE + 32'h101, 8'h00, 32'd0, 8'h00);
        send_request(MODE_LOOKUP, STAY_ID_BASE + 32'h100, 8'($urandom()), $urandom(),
            8'($urandom()));
    endtask

    initial
    begin
        clear_directory();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_directory();
        test_slot_replacement();
        test_permanent_area();
        test_random_traffic();
        test_offset_saturation();

        // drain, then give the block time to show any stray result
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sdsd_pkg.sv
hw/rtl/sdsd_slot_store.sv
hw/rtl/sound_data_slot_directory.sv
hw/rtl/sdsd_checker.sv
verif/sound_data_slot_directory_test.sv
